[hw/rtl/gcr_disk_read_write_logic_macros.svh]
// Assertion macros shared by the GCR read/write logic.
`ifndef GCR_DISK_READ_WRITE_LOGIC_MACROS_SVH
`define GCR_DISK_READ_WRITE_LOGIC_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define GCR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define GCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/gcr_pkg.sv]
// Types and constants of the GCR read/write logic.
package gcr_pkg;

   localparam logic [9:0] SYNC_ALL_ONES = 10'h3FF;
   localparam logic [2:0] BYTE_LAST     = 3'd7;

   localparam logic [1:0] CELL_EVAL_A = 2'd0;
   localparam logic [1:0] CELL_EVAL_B = 2'd1;
   localparam logic [1:0] CELL_SHIFT  = 2'd2;
   localparam logic [1:0] CELL_LOAD   = 2'd3;

   localparam logic FUNC_CARRY = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   typedef struct packed {
      logic       func;
      logic       read_mode;
      logic       write_mode;
      logic       disk_present;
      logic       barrier_blocked;
      logic       head_bit;
      logic [7:0] port_byte;
      logic       byte_sync_enable;
   } item_type;

   typedef struct packed {
      logic [3:0] bit_cell_count;
      logic [1:0] phase_count;
      logic [9:0] read_shift;
      logic [7:0] write_shift;
      logic [2:0] byte_count;
      logic       ready_level;
      logic       sync_level;
   } state_type;

   typedef struct packed {
      logic       byte_ready;
      logic       byte_ready_changed;
      logic       sync_n;
      logic [7:0] read_data;
      logic       write_strobe;
      logic       write_bit;
      logic       rotate_pulse;
   } result_type;

   localparam state_type STATE_RESET = '{
      bit_cell_count: 4'd0,
      phase_count:    2'd0,
      read_shift:     10'd0,
      write_shift:    8'd0,
      byte_count:     3'd0,
      ready_level:    1'b1,
      sync_level:     1'b1
   };

endpackage

[hw/rtl/gcr_step.sv]
// Next-state and result logic for one carry pulse or CPU tick.
module gcr_step import gcr_pkg::*; (
   input  state_type  state,
   input  item_type   item,
   output state_type  state_next,
   output result_type result
);

   logic [3:0] cell_next;
   logic [1:0] phase;
   logic [2:0] bytes;
   logic       sync;
   logic       strobe;
   logic       wbit;
   logic       rotate;

   always_comb begin
      state_next = state;
      cell_next  = state.bit_cell_count + 4'd1;
      phase      = state.phase_count + 2'd1;
      rotate     = 1'b0;
      strobe     = 1'b0;
      wbit       = 1'b0;
      sync       = state.sync_level;
      bytes      = state.byte_count;
      if (item.func == FUNC_TICK) begin
         state_next.ready_level = ~(item.byte_sync_enable & ~state.bit_cell_count[1]
                                    & (state.byte_count == BYTE_LAST));
      end else begin
         if (phase == 2'd0) begin
            if (item.read_mode && item.disk_present && item.head_bit) begin
               cell_next = 4'd0;
            end
            rotate = item.disk_present;
         end
         sync  = (state.read_shift != SYNC_ALL_ONES) | item.write_mode;
         bytes = sync ? state.byte_count : 3'd0;
         state_next.bit_cell_count = cell_next;
         state_next.phase_count    = phase;
         state_next.sync_level     = sync;
         state_next.byte_count     = bytes;
         unique case (cell_next[1:0])
            CELL_EVAL_A, CELL_EVAL_B: begin
               state_next.ready_level = ~(item.byte_sync_enable & ~cell_next[1]
                                          & (bytes == BYTE_LAST));
            end
            CELL_SHIFT: begin
               state_next.ready_level = 1'b1;
               state_next.byte_count  = sync ? bytes + 3'd1 : 3'd0;
               if (item.write_mode && item.disk_present && !item.barrier_blocked) begin
                  strobe = 1'b1;
                  wbit   = state.write_shift[7];
               end
               state_next.write_shift = {state.write_shift[6:0], 1'b0};
               state_next.read_shift  = {state.read_shift[8:0], (cell_next[3:2] == 2'd0)};
            end
            CELL_LOAD: begin
               if (bytes == BYTE_LAST) begin
                  state_next.write_shift = item.port_byte;
               end
            end
         endcase
      end
   end

   assign result.byte_ready         = state_next.ready_level;
   assign result.byte_ready_changed = state_next.ready_level ^ state.ready_level;
   assign result.sync_n             = state_next.sync_level;
   assign result.read_data          = state_next.read_shift[7:0];
   assign result.write_strobe       = strobe;
   assign result.write_bit          = wbit;
   assign result.rotate_pulse       = rotate;

endmodule

[hw/rtl/gcr_rsp_reg.sv]
// Result register holding one word until the consumer takes it.
module gcr_rsp_reg import gcr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type data_in,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output result_type data_out
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign data_out  = data_ff;

endmodule

[hw/rtl/gcr_disk_read_write_logic.sv]
// Top level of the GCR floppy read/write logic: state registers and result register.
//
//  channel | direction | ports                          | accepted when
//  req     | in        | req_valid, req_stall, req_*    | req_valid and not req_stall
//  rsp     | out       | rsp_valid, rsp_stall, rsp_*    | rsp_valid and not rsp_stall
//
// Each word takes a single pass of counter and shift logic between the state registers
// and the result register, so one word is accepted per clock while req_stall is low.
// A result appears on the rsp side the cycle after its word is accepted.
// Reset is synchronous; it clears the state to its idle values and empties the result.
// req_stall is raised only while a result is waiting and rsp_stall is high.
`include "gcr_disk_read_write_logic_macros.svh"

module gcr_disk_read_write_logic import gcr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic       req_read_mode,
   input  logic       req_write_mode,
   input  logic       req_disk_present,
   input  logic       req_barrier_blocked,
   input  logic       req_head_bit,
   input  logic [7:0] req_port_byte,
   input  logic       req_byte_sync_enable,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_byte_ready,
   output logic       rsp_byte_ready_changed,
   output logic       rsp_sync_n,
   output logic [7:0] rsp_read_data,
   output logic       rsp_write_strobe,
   output logic       rsp_write_bit,
   output logic       rsp_rotate_pulse
);

   state_type  state_ff;
   state_type  state_in;
   item_type   item;
   result_type result;
   result_type rsp_data;
   logic       accept;

   assign item = '{
      func:             req_func,
      read_mode:        req_read_mode,
      write_mode:       req_write_mode,
      disk_present:     req_disk_present,
      barrier_blocked:  req_barrier_blocked,
      head_bit:         req_head_bit,
      port_byte:        req_port_byte,
      byte_sync_enable: req_byte_sync_enable
   };

   assign req_stall = rsp_valid & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   gcr_step u_step (
      .state      (state_ff),
      .item       (item),
      .state_next (state_in),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   gcr_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .data_in   (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .data_out  (rsp_data)
   );

   assign rsp_byte_ready         = rsp_data.byte_ready;
   assign rsp_byte_ready_changed = rsp_data.byte_ready_changed;
   assign rsp_sync_n             = rsp_data.sync_n;
   assign rsp_read_data          = rsp_data.read_data;
   assign rsp_write_strobe       = rsp_data.write_strobe;
   assign rsp_write_bit          = rsp_data.write_bit;
   assign rsp_rotate_pulse       = rsp_data.rotate_pulse;

   `GCR_ASSERT_SAME(a_wbit_needs_strobe, clock, reset, rsp_valid && rsp_write_bit, rsp_write_strobe, "write bit set without a write strobe")
   `GCR_ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid, "accepted word produced no result")
   `GCR_ASSERT_NEXT(a_tick_keeps_counters, clock, reset, accept && req_func == FUNC_TICK, $stable(state_ff.bit_cell_count) && $stable(state_ff.read_shift), "CPU tick changed the counters or the read register")
   `GCR_ASSERT_NEXT(a_carry_steps_phase, clock, reset, accept && req_func == FUNC_CARRY, state_ff.phase_count == 2'($past(state_ff.phase_count) + 2'd1), "carry pulse did not advance the phase counter")

endmodule
